/* rtl/core/per_cell_online_mean_variance_core_assert.svh */
// Assertion macros shared by the per-cell statistics RTL.
`ifndef PER_CELL_ONLINE_MEAN_VARIANCE_CORE_ASSERT_SVH
`define PER_CELL_ONLINE_MEAN_VARIANCE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PCMV_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcmv assertion failed");
`define PCMV_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcmv assertion failed");
`else
`define PCMV_ASSERT_IMP(name, ante, cons)
`define PCMV_ASSERT_NXT(name, ante, cons)
`endif
`endif

/* rtl/core/pcmv_pkg.sv */
// Shared types, widths, codes and helpers of the per-cell statistics core.
package pcmv_pkg;

    localparam int DEVICES_DEF    = 16;
    localparam int ACTIVITIES_DEF = 16;

    localparam int WORD_W     = 32;
    localparam int DMEAN_W    = 48;
    localparam int SSUM_W     = 64;
    localparam int DIVIDEND_W = 64;
    localparam int ROOT_IN_W  = 64;

    localparam logic [1:0] MODE_HIT    = 2'd0;
    localparam logic [1:0] MODE_LEN    = 2'd1;
    localparam logic [1:0] MODE_DELTA  = 2'd2;
    localparam logic [1:0] MODE_IGNORE = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0]  pair_hits;
        logic [WORD_W-1:0]  length_count;
        logic [WORD_W-1:0]  length_mean;
        logic [WORD_W-1:0]  delta_count;
        logic [DMEAN_W-1:0] delta_mean;
        logic [SSUM_W-1:0]  square_sum;
        logic [WORD_W-1:0]  delta_spread;
    } cell_row_t;

    localparam int ROW_W = $bits(cell_row_t);

    function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

/* rtl/core/pcmv_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module pcmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/pcmv_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module pcmv_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [pcmv_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [pcmv_pkg::WORD_W-1:0]      divisor,
    output logic                             done,
    output logic [pcmv_pkg::DIVIDEND_W-1:0]  quotient
);
    import pcmv_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0]     rem_reg, rem_next;
    logic [WORD_W-1:0]     dsr_reg, dsr_next;
    logic [WORD_W:0]       shifted;
    logic [WORD_W:0]       trial;
    logic                  fits;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        fits      = (shifted >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/pcmv_mul.sv */
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
module pcmv_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pcmv_pkg::WORD_W-1:0]   op_a,
    input  logic [pcmv_pkg::WORD_W-1:0]   op_b,
    output logic                          done,
    output logic [2*pcmv_pkg::WORD_W-1:0] product
);
    import pcmv_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [WORD_W-1:0]     a_reg, a_next;
    logic [2*WORD_W-1:0]   prod_reg, prod_next;
    logic [WORD_W:0]       part;

    always_comb begin
        part      = {1'b0, prod_reg[2*WORD_W-1:WORD_W]}
                  + (prod_reg[0] ? {1'b0, a_reg} : '0);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        prod_next = prod_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_W - 1);
            a_next    = op_a;
            prod_next = {{WORD_W{1'b0}}, op_b};
        end else if (busy_reg) begin
            prod_next = {part, prod_reg[WORD_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        prod_reg <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

/* rtl/core/pcmv_sqrt.sv */
// Bit-serial integer square root: one root bit per cycle.
module pcmv_sqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [pcmv_pkg::ROOT_IN_W-1:0]  radicand,
    output logic                            done,
    output logic [pcmv_pkg::ROOT_IN_W/2-1:0] root
);
    import pcmv_pkg::*;

    localparam int RT_W  = ROOT_IN_W / 2;
    localparam int REM_W = RT_W + 2;
    localparam int CNT_W = $clog2(RT_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ROOT_IN_W-1:0] rad_reg, rad_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [RT_W-1:0]      root_reg, root_next;
    logic [REM_W+1:0]     rem_sh;
    logic [REM_W+1:0]     trial;
    logic                 fits;

    always_comb begin
        rem_sh    = {rem_reg, rad_reg[ROOT_IN_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        fits      = (rem_sh >= trial);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RT_W - 1);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rem_next  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_next = {root_reg[RT_W-2:0], fits};
            rad_next  = {rad_reg[ROOT_IN_W-3:0], 2'b00};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/core/per_cell_online_mean_variance_core.sv */
// Top level of the per-cell online mean and standard deviation core.
// Keeps hit counts, a running length mean and a Welford delta mean, sum of squares and
// sigma for every device/activity cell, one item at a time. After reset the tables are
// cleared by a pass over every cell, during which no item is taken. A hit item only reads
// and writes back its row, a length item adds one bit-serial division, and a delta item
// from the second one in its cell on runs the divider twice (mean update, then S/(n-1)),
// with a serial multiplier between the two and a serial square root after the second.
// A finished result waits in the output register while the next item is taken in.
`include "per_cell_online_mean_variance_core_assert.svh"
module per_cell_online_mean_variance_core #(
    parameter int DEVICES    = pcmv_pkg::DEVICES_DEF,
    parameter int ACTIVITIES = pcmv_pkg::ACTIVITIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [3:0]         s_device_index,
    input  logic [3:0]         s_activity_index,
    input  logic [15:0]        s_length_value,
    input  logic signed [31:0] s_delta_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_cell_count,
    output logic [31:0]        m_device_total,
    output logic signed [31:0] m_running_mean,
    output logic [31:0]        m_spread
);
    import pcmv_pkg::*;

    localparam int CELLS  = DEVICES * ACTIVITIES;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_DIV1   = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_DIV2   = 3'd5;
    localparam logic [2:0] ST_SQRT   = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [CELL_W-1:0]   clr_idx_reg, clr_idx_next;
    logic                item_ok_reg, item_ok_next;
    logic [1:0]          mode_reg, mode_next;
    logic [CELL_W-1:0]   cell_reg, cell_next;
    logic [DEV_W-1:0]    dev_reg, dev_next;
    logic [15:0]         len_reg, len_next;
    logic [WORD_W-1:0]   delta_reg, delta_next;
    cell_row_t           row_reg, row_next;
    logic [WORD_W-1:0]   devh_reg, devh_next;
    logic                neg_reg, neg_next;
    logic [WORD_W-1:0]   d1m_reg, d1m_next;

    logic                m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]   cnt_out_reg, cnt_out_next;
    logic [WORD_W-1:0]   tot_out_reg, tot_out_next;
    logic [WORD_W-1:0]   mean_out_reg, mean_out_next;
    logic [WORD_W-1:0]   spr_out_reg, spr_out_next;

    logic [15:0]         s_cell_full;
    logic                s_item_ok;
    logic                cell_we, dev_we;
    logic [CELL_W-1:0]   cell_waddr, cell_raddr;
    logic [DEV_W-1:0]    dev_waddr, dev_raddr;
    logic [ROW_W-1:0]    cell_wdata, cell_rdata;
    logic [WORD_W-1:0]   dev_wdata, dev_rdata;
    cell_row_t           row_in;

    logic                div_start, div_done;
    logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
    logic [WORD_W-1:0]   div_divisor;
    logic                mul_start, mul_done;
    logic [WORD_W-1:0]   mul_a, mul_b;
    logic [2*WORD_W-1:0] mul_product;
    logic                sqrt_start, sqrt_done;
    logic [WORD_W-1:0]   sqrt_root;

    logic [WORD_W:0]     ldiff, lmag;
    logic [DMEAN_W:0]    d1, d1mag, d2, d2mag;
    logic [DMEAN_W-1:0]  xval, dq, dmean_new;
    logic [WORD_W-1:0]   lq;
    logic [SSUM_W:0]     ssum_wide;
    logic [SSUM_W-1:0]   ssum_new;

    assign s_cell_full = 16'(s_device_index) * 16'(ACTIVITIES) + 16'(s_activity_index);
    assign s_item_ok   = (s_mode != MODE_IGNORE) && (32'(s_device_index) < DEVICES)
                       && (32'(s_activity_index) < ACTIVITIES);
    assign s_ready     = (state_reg == ST_IDLE);
    assign row_in      = cell_row_t'(cell_rdata);

    assign cell_raddr = (state_reg == ST_IDLE) ? s_cell_full[CELL_W-1:0] : cell_reg;
    assign dev_raddr  = (state_reg == ST_IDLE) ? DEV_W'(s_device_index) : dev_reg;

    // The clearing pass shares the write ports with the final write-back.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            cell_we    = 1'b1;
            cell_waddr = clr_idx_reg;
            cell_wdata = '0;
            dev_we     = (32'(clr_idx_reg) < DEVICES);
            dev_waddr  = clr_idx_reg[DEV_W-1:0];
            dev_wdata  = '0;
        end else begin
            cell_we    = (state_reg == ST_FINISH) && item_ok_reg;
            cell_waddr = cell_reg;
            cell_wdata = row_reg;
            dev_we     = cell_we;
            dev_waddr  = dev_reg;
            dev_wdata  = devh_reg;
        end
    end

    always_comb begin
        xval      = {delta_reg, 16'h0000};
        ldiff     = {5'b0, len_reg, 12'h000} - {1'b0, row_in.length_mean};
        lmag      = ldiff[WORD_W] ? -ldiff : ldiff;
        d1        = {xval[DMEAN_W-1], xval} - {row_in.delta_mean[DMEAN_W-1], row_in.delta_mean};
        d1mag     = d1[DMEAN_W] ? -d1 : d1;
        lq        = neg_reg ? -div_quotient[WORD_W-1:0] : div_quotient[WORD_W-1:0];
        dq        = neg_reg ? -div_quotient[DMEAN_W-1:0] : div_quotient[DMEAN_W-1:0];
        dmean_new = row_reg.delta_mean + dq;
        d2        = {xval[DMEAN_W-1], xval} - {dmean_new[DMEAN_W-1], dmean_new};
        d2mag     = d2[DMEAN_W] ? -d2 : d2;
        ssum_wide = {1'b0, row_reg.square_sum} + {1'b0, mul_product};
        ssum_new  = ssum_wide[SSUM_W] ? {SSUM_W{1'b1}} : ssum_wide[SSUM_W-1:0];

        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        item_ok_next  = item_ok_reg;
        mode_next     = mode_reg;
        cell_next     = cell_reg;
        dev_next      = dev_reg;
        len_next      = len_reg;
        delta_next    = delta_reg;
        row_next      = row_reg;
        devh_next     = devh_reg;
        neg_next      = neg_reg;
        d1m_next      = d1m_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cnt_out_next  = cnt_out_reg;
        tot_out_next  = tot_out_reg;
        mean_out_next = mean_out_reg;
        spr_out_next  = spr_out_reg;
        div_start     = 1'b0;
        div_dividend  = '0;
        div_divisor   = '0;
        mul_start     = 1'b0;
        mul_a         = d1m_reg;
        mul_b         = d2mag[DMEAN_W-1:16];
        sqrt_start    = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == CELL_W'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    item_ok_next = s_item_ok;
                    mode_next    = s_mode;
                    cell_next    = s_cell_full[CELL_W-1:0];
                    dev_next     = DEV_W'(s_device_index);
                    len_next     = s_length_value;
                    delta_next   = s_delta_value;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                row_next  = row_in;
                devh_next = dev_rdata;
                if (!item_ok_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    unique case (mode_reg)
                        MODE_HIT: begin
                            row_next.pair_hits = sat_inc(row_in.pair_hits);
                            devh_next          = sat_inc(dev_rdata);
                            state_next         = ST_FINISH;
                        end
                        MODE_LEN: begin
                            row_next.length_count = sat_inc(row_in.length_count);
                            neg_next     = ldiff[WORD_W];
                            div_start    = 1'b1;
                            div_dividend = DIVIDEND_W'(lmag);
                            div_divisor  = sat_inc(row_in.length_count);
                            state_next   = ST_DIV1;
                        end
                        default: begin
                            row_next.delta_count = sat_inc(row_in.delta_count);
                            neg_next     = d1[DMEAN_W];
                            d1m_next     = d1mag[DMEAN_W-1:16];
                            div_start    = 1'b1;
                            div_dividend = DIVIDEND_W'(d1mag);
                            div_divisor  = sat_inc(row_in.delta_count);
                            state_next   = ST_DIV1;
                        end
                    endcase
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    if (mode_reg == MODE_LEN) begin
                        row_next.length_mean = row_reg.length_mean + lq;
                        state_next           = ST_FINISH;
                    end else begin
                        row_next.delta_mean = dmean_new;
                        mul_start           = 1'b1;
                        state_next          = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    row_next.square_sum = ssum_new;
                    if (row_reg.delta_count < 32'd2) begin
                        row_next.delta_spread = '0;
                        state_next            = ST_FINISH;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = ssum_new;
                        div_divisor  = row_reg.delta_count - 1'b1;
                        state_next   = ST_DIV2;
                    end
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    sqrt_start = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    row_next.delta_spread = sqrt_root;
                    state_next            = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hold here until the output register is free for the result.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    cnt_out_next  = '0;
                    tot_out_next  = '0;
                    mean_out_next = '0;
                    spr_out_next  = '0;
                    if (item_ok_reg) begin
                        tot_out_next = devh_reg;
                        unique case (mode_reg)
                            MODE_HIT: begin
                                cnt_out_next = row_reg.pair_hits;
                            end
                            MODE_LEN: begin
                                cnt_out_next  = row_reg.length_count;
                                mean_out_next = row_reg.length_mean;
                            end
                            default: begin
                                cnt_out_next  = row_reg.delta_count;
                                mean_out_next = row_reg.delta_mean[DMEAN_W-1:16];
                                spr_out_next  = row_reg.delta_spread;
                            end
                        endcase
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
        end
        item_ok_reg  <= item_ok_next;
        mode_reg     <= mode_next;
        cell_reg     <= cell_next;
        dev_reg      <= dev_next;
        len_reg      <= len_next;
        delta_reg    <= delta_next;
        row_reg      <= row_next;
        devh_reg     <= devh_next;
        neg_reg      <= neg_next;
        d1m_reg      <= d1m_next;
        cnt_out_reg  <= cnt_out_next;
        tot_out_reg  <= tot_out_next;
        mean_out_reg <= mean_out_next;
        spr_out_reg  <= spr_out_next;
    end

    pcmv_ram #(.WIDTH(ROW_W), .DEPTH(CELLS)) u_cell_ram (
        .aclk  (aclk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    pcmv_ram #(.WIDTH(WORD_W), .DEPTH(DEVICES)) u_dev_ram (
        .aclk  (aclk),
        .we    (dev_we),
        .waddr (dev_waddr),
        .wdata (dev_wdata),
        .raddr (dev_raddr),
        .rdata (dev_rdata)
    );

    pcmv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    pcmv_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    pcmv_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_quotient),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign m_valid        = m_valid_reg;
    assign m_cell_count   = cnt_out_reg;
    assign m_device_total = tot_out_reg;
    assign m_running_mean = mean_out_reg;
    assign m_spread       = spr_out_reg;

    `PCMV_ASSERT_IMP(a_div_done_in_div, div_done, (state_reg == ST_DIV1) || (state_reg == ST_DIV2))
    `PCMV_ASSERT_NXT(a_accept_reads, s_valid && s_ready, state_reg == ST_READ)
    `PCMV_ASSERT_IMP(a_result_from_finish, $rose(m_valid_reg), $past(state_reg) == ST_FINISH)
    `PCMV_ASSERT_IMP(a_writeback_valid, cell_we && (state_reg != ST_CLEAR), item_ok_reg)

endmodule
